// ----- sv/bsm_pkg.sv -----
// Shared types and constants of the bank switch mapper with security latch.
package bsm_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_SCANLINE = 2'd2,
    OP_RESET    = 2'd3
  } bsm_op_e;

  typedef enum logic {
    CFG_ALT_CHR_MODE   = 1'b0,
    CFG_START_PRG_BANK = 1'b1
  } bsm_cfg_idx_e;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned LineW   = 9;
  localparam int unsigned PrgW    = 12;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 24;

  localparam logic [AddrW-1:0] ADDR_RAM_BASE    = 16'h6000;
  localparam logic [AddrW-1:0] ADDR_WIN_BASE    = 16'h4020;
  localparam logic [AddrW-1:0] ADDR_READ_BASE   = 16'h5000;
  localparam logic [AddrW-1:0] ADDR_STROBE      = 16'h5101;
  localparam logic [AddrW-1:0] ADDR_FORCE       = 16'h5100;
  localparam logic [AddrW-1:0] WR_DECODE_MASK   = 16'h7300;
  localparam logic [AddrW-1:0] RD_DECODE_MASK   = 16'h7700;
  localparam logic [AddrW-1:0] WR_SEL_LOW_CTRL  = 16'h5000;
  localparam logic [AddrW-1:0] WR_SEL_HIGH_BITS = 16'h5200;
  localparam logic [AddrW-1:0] WR_SEL_SECURITY  = 16'h5300;
  localparam logic [AddrW-1:0] RD_SEL_SECURITY  = 16'h5100;
  localparam logic [AddrW-1:0] RD_SEL_GATED     = 16'h5500;

  localparam logic [DataW-1:0] FORCE_DATA     = 8'd6;
  localparam logic [DataW-1:0] READ_DEFAULT   = 8'd4;
  localparam logic [PrgW-1:0]  FORCED_PRG     = 12'd3;
  localparam logic [PrgW-1:0]  START_PRG_RST  = 12'd15;
  localparam logic [LineW-1:0] LINE_SPLIT     = 9'd128;
  localparam logic [LineW-1:0] LINE_LAST      = 9'd239;

  typedef struct packed {
    bsm_op_e          operation;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
    logic [LineW-1:0] scanline;
    logic             rendering_on;
  } bsm_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             ram_access;
    logic [PrgW-1:0]  prg_bank;
    logic             chr_low_page;
    logic             chr_high_page;
  } bsm_result_t;

  typedef struct packed {
    logic            alt_chr_mode;
    logic [PrgW-1:0] start_prg_bank;
  } bsm_cfg_t;

endpackage

// ----- sv/bsm_core.sv -----
// Mapper state registers with the decode and update logic for one item.
module bsm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  bsm_pkg::bsm_item_t  item_i,
  input  bsm_pkg::bsm_cfg_t   cfg_i,
  output bsm_pkg::bsm_result_t result_o
);
  import bsm_pkg::*;

  logic [DataW-1:0] high_bits_q, high_bits_d;
  logic [DataW-1:0] low_ctrl_q, low_ctrl_d;
  logic [DataW-1:0] security_q, security_d;
  logic             strobe_q, strobe_d;
  logic             trigger_q, trigger_d;
  logic [PrgW-1:0]  prg_q, prg_d;
  logic             chr_low_q, chr_low_d;
  logic             chr_high_q, chr_high_d;
  logic [DataW-1:0] read_data;
  logic             ram_access;
  logic             line_below_split;

  assign line_below_split = item_i.scanline < LINE_SPLIT;

  always_comb begin
    high_bits_d = high_bits_q;
    low_ctrl_d  = low_ctrl_q;
    security_d  = security_q;
    strobe_d    = strobe_q;
    trigger_d   = trigger_q;
    prg_d       = prg_q;
    chr_low_d   = chr_low_q;
    chr_high_d  = chr_high_q;
    read_data   = '0;
    ram_access  = 1'b0;
    case (item_i.operation)
      OP_WRITE: begin
        if (item_i.address >= ADDR_RAM_BASE) begin
          ram_access = 1'b1;
        end else if (item_i.address >= ADDR_WIN_BASE) begin
          if (item_i.address == ADDR_STROBE) begin
            if (strobe_q && (item_i.write_data == '0)) begin
              trigger_d = ~trigger_q;
            end
            strobe_d = item_i.write_data != '0;
          end else if ((item_i.address == ADDR_FORCE) &&
                       (item_i.write_data == FORCE_DATA)) begin
            prg_d = FORCED_PRG;
          end else begin
            case (item_i.address & WR_DECODE_MASK)
              WR_SEL_LOW_CTRL: begin
                low_ctrl_d = item_i.write_data;
                prg_d      = {high_bits_q, item_i.write_data[3:0]};
                if ((!item_i.write_data[7] && line_below_split) || cfg_i.alt_chr_mode) begin
                  chr_low_d  = 1'b0;
                  chr_high_d = 1'b1;
                end
              end
              WR_SEL_HIGH_BITS: begin
                high_bits_d = item_i.write_data;
                prg_d       = {item_i.write_data, low_ctrl_q[3:0]};
              end
              WR_SEL_SECURITY: begin
                security_d = item_i.write_data;
              end
              default: begin
              end
            endcase
          end
        end
      end
      OP_READ: begin
        if (item_i.address >= ADDR_RAM_BASE) begin
          ram_access = 1'b1;
        end else if (item_i.address >= ADDR_READ_BASE) begin
          case (item_i.address & RD_DECODE_MASK)
            RD_SEL_SECURITY: read_data = security_q;
            RD_SEL_GATED:    read_data = trigger_q ? security_q : '0;
            default:         read_data = READ_DEFAULT;
          endcase
        end else begin
          // Open bus: the high address byte is still on the data lines.
          read_data = item_i.address[AddrW-1:AddrW-DataW];
        end
      end
      OP_SCANLINE: begin
        if (low_ctrl_q[7] && item_i.rendering_on) begin
          if (item_i.scanline == LINE_SPLIT) begin
            chr_low_d  = 1'b1;
            chr_high_d = 1'b1;
          end
          if (cfg_i.alt_chr_mode) begin
            if (line_below_split) begin
              chr_low_d  = 1'b0;
              chr_high_d = 1'b0;
            end
          end else if (item_i.scanline == LINE_LAST) begin
            chr_low_d  = 1'b0;
            chr_high_d = 1'b0;
          end
        end
      end
      OP_RESET: begin
        high_bits_d = '0;
        low_ctrl_d  = '1;
        security_d  = '0;
        strobe_d    = 1'b1;
        trigger_d   = 1'b0;
        prg_d       = cfg_i.start_prg_bank;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_bits_q <= '0;
      low_ctrl_q  <= '1;
      security_q  <= '0;
      strobe_q    <= 1'b1;
      trigger_q   <= 1'b0;
      prg_q       <= START_PRG_RST;
      chr_low_q   <= 1'b0;
      chr_high_q  <= 1'b1;
    end else if (fire_i) begin
      high_bits_q <= high_bits_d;
      low_ctrl_q  <= low_ctrl_d;
      security_q  <= security_d;
      strobe_q    <= strobe_d;
      trigger_q   <= trigger_d;
      prg_q       <= prg_d;
      chr_low_q   <= chr_low_d;
      chr_high_q  <= chr_high_d;
    end
  end

  assign result_o.read_data     = read_data;
  assign result_o.ram_access    = ram_access;
  assign result_o.prg_bank      = prg_d;
  assign result_o.chr_low_page  = chr_low_d;
  assign result_o.chr_high_page = chr_high_d;

  // The page pair only ever takes the layouts (0,1), (1,1) and (0,0).
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(chr_low_q && !chr_high_q))
    else $error("pattern pages reached an impossible layout");

  // The program bank always follows the bank bytes after a low control write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.operation == OP_WRITE && item_i.address < ADDR_RAM_BASE &&
     item_i.address >= ADDR_WIN_BASE && item_i.address != ADDR_STROBE &&
     item_i.address != ADDR_FORCE &&
     (item_i.address & WR_DECODE_MASK) == WR_SEL_LOW_CTRL)
    |=> prg_q == {high_bits_q, low_ctrl_q[3:0]})
    else $error("program bank out of step with bank bytes");

endmodule

// ----- sv/bank_switch_mapper_with_security_latch.sv -----
// Top level of the bank switch mapper: stream ports, configuration and pipeline registers.
//
//  Channel   Direction  Transfer when                   Contents
//  s_axis    in         s_axis_tvalid & s_axis_tready   one CPU access, scanline or reset
//  m_axis    out        m_axis_tvalid & m_axis_tready   one result per input item
//  cfg       in         cfg_valid_i & cfg_ready_o       register index and value
//
// Every item passes two registers from input transfer to result transfer: first the input
// register and then the result register, with the decode and state update between.
// A new item is accepted every cycle; the rate is one item per cycle as long as the
// result side keeps taking transfers.
// When the result register is full and not taken, the input register holds its item and
// accepts no new one only once it is full too. Reset empties both stages and loads the
// mapper state with its power-on values; the configuration port is always ready.
module bank_switch_mapper_with_security_latch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: address[15:0], write_data[23:16], scanline[32:24], rendering_on[33], zero pad.
  input  logic [bsm_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: operation[1:0].
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: read_data[7:0], ram_access[8], prg_bank[20:9], chr_low_page[21],
  // chr_high_page[22], zero pad.
  output logic [bsm_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [bsm_pkg::PrgW-1:0]      cfg_data_i
);
  import bsm_pkg::*;

  bsm_item_t   item_q, item_d;
  logic        in_valid_q;
  bsm_result_t result_q, result_d;
  logic        out_valid_q;
  bsm_cfg_t    cfg_q;
  logic        advance;
  logic        in_xfer;

  // The input stage moves forward whenever the result register is empty or being taken.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign item_d.operation    = bsm_op_e'(s_axis_tuser);
  assign item_d.address      = s_axis_tdata[15:0];
  assign item_d.write_data   = s_axis_tdata[23:16];
  assign item_d.scanline     = s_axis_tdata[32:24];
  assign item_d.rendering_on = s_axis_tdata[33];

  // Configuration registers; the user writes only while no item is in flight; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alt_chr_mode   <= 1'b0;
      cfg_q.start_prg_bank <= START_PRG_RST;
    end else if (cfg_valid_i) begin
      case (bsm_cfg_idx_e'(cfg_index_i))
        CFG_ALT_CHR_MODE:   cfg_q.alt_chr_mode   <= cfg_data_i[0];
        CFG_START_PRG_BANK: cfg_q.start_prg_bank <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_d;
    end
  end

  // Decode and state update; the state commits when the item enters the result register.
  bsm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q.chr_high_page, result_q.chr_low_page,
                          result_q.prg_bank, result_q.ram_access, result_q.read_data};

  // The input side stalls only while the input register holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !s_axis_tready |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // A work RAM access never carries read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.ram_access) |-> result_q.read_data == '0)
    else $error("work RAM access returned mapper data");

  // A reset operation leaves the configured start bank in the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.operation == OP_RESET) |=>
    result_q.prg_bank == $past(cfg_q.start_prg_bank))
    else $error("reset operation did not load the start bank");

  // An item only enters the result register when that register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !advance)
    else $error("result overwritten while stalled");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the bank switch mapper with security latch.
module testbench;
  import bsm_pkg::*;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is a sender gap plus a receiver stall plus the passage
  // through the input and result registers.
  localparam int unsigned STUCK_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned PHASE_ITEMS = 300;

  // Decode constants of the mapper, kept here independent of the design package.
  localparam logic [15:0] RAM_BASE       = 16'h6000;
  localparam logic [15:0] WINDOW_BASE    = 16'h4020;
  localparam logic [15:0] READ_BASE      = 16'h5000;
  localparam logic [15:0] STROBE_ADDR    = 16'h5101;
  localparam logic [15:0] FORCE_ADDR     = 16'h5100;
  localparam logic [15:0] WRITE_MASK     = 16'h7300;
  localparam logic [15:0] READ_MASK      = 16'h7700;
  localparam logic [15:0] LOW_CTRL_SEL   = 16'h5000;
  localparam logic [15:0] HIGH_BITS_SEL  = 16'h5200;
  localparam logic [15:0] SECURITY_SEL   = 16'h5300;
  localparam logic [15:0] SEC_READ_SEL   = 16'h5100;
  localparam logic [15:0] GATED_READ_SEL = 16'h5500;
  localparam logic [7:0]  FORCE_BYTE     = 8'd6;
  localparam logic [7:0]  UNMAPPED_BYTE  = 8'd4;
  localparam logic [11:0] FORCED_BANK    = 12'd3;
  localparam logic [11:0] RESET_START    = 12'd15;
  localparam logic [8:0]  SPLIT_LINE     = 9'd128;
  localparam logic [8:0]  LAST_LINE      = 9'd239;

  // One row of the corner-case table. Rows with a hand-written result are checked
  // against that value; the others go through the mapper model below.
  typedef struct {
    bsm_item_t   access;
    logic        typed;
    bsm_result_t want;
  } access_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [PrgW-1:0]     cfg_data_i;

  // Travels with the input transfer so that the monitor knows which rows carry
  // a hand-written result.
  logic        row_typed;
  bsm_result_t row_want;

  // Random gaps on the input side and stalls on the result side; both are turned
  // off for the last phase.
  bit gaps_on;
  bit stalls_on;

  // Mapper model state and its copy of the configuration registers.
  logic        alt_mode;
  logic [11:0] start_bank;
  logic [7:0]  high_bits;
  logic [7:0]  low_ctrl;
  logic [7:0]  security;
  logic        strobe;
  logic        trigger;
  logic [11:0] prg;
  logic        page_lo;
  logic        page_hi;

  bsm_result_t pending_q[$];
  int unsigned fault_count;
  int unsigned n_accesses;
  int unsigned n_results;
  int unsigned stuck_cycles;

  bank_switch_mapper_with_security_latch i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The reset operation restores the banking and the latch, but not the pattern
  // pages or the configuration.
  function automatic void restart_banks();
    high_bits = '0;
    low_ctrl  = 8'hFF;
    security  = '0;
    strobe    = 1'b1;
    trigger   = 1'b0;
    prg       = start_bank;
  endfunction

  // Applies one access to the mapper model and returns the banking it leaves.
  function automatic bsm_result_t map_access(bsm_item_t a);
    bsm_result_t r;
    r = '0;
    case (a.operation)
      OP_WRITE: begin
        if (a.address >= RAM_BASE) begin
          r.ram_access = 1'b1;
        end else if (a.address >= WINDOW_BASE) begin
          // The strobe and the forced bank are decoded on the full address,
          // ahead of the masked register groups.
          if (a.address == STROBE_ADDR) begin
            if (strobe && a.write_data == '0) trigger = ~trigger;
            strobe = (a.write_data != '0);
          end else if (a.address == FORCE_ADDR && a.write_data == FORCE_BYTE) begin
            prg = FORCED_BANK;
          end else begin
            case (a.address & WRITE_MASK)
              LOW_CTRL_SEL: begin
                low_ctrl = a.write_data;
                prg = {high_bits, low_ctrl[3:0]};
                if (!low_ctrl[7] && a.scanline < SPLIT_LINE) begin
                  page_lo = 1'b0;
                  page_hi = 1'b1;
                end
                if (alt_mode) begin
                  page_lo = 1'b0;
                  page_hi = 1'b1;
                end
              end
              HIGH_BITS_SEL: begin
                high_bits = a.write_data;
                prg = {high_bits, low_ctrl[3:0]};
              end
              SECURITY_SEL: security = a.write_data;
              default: ;
            endcase
          end
        end
      end
      OP_READ: begin
        if (a.address >= RAM_BASE) begin
          r.ram_access = 1'b1;
        end else if (a.address >= READ_BASE) begin
          case (a.address & READ_MASK)
            SEC_READ_SEL:   r.read_data = security;
            GATED_READ_SEL: r.read_data = trigger ? security : 8'h00;
            default:        r.read_data = UNMAPPED_BYTE;
          endcase
        end else begin
          // Below the mapper window the bus floats to the high address byte.
          r.read_data = a.address[15:8];
        end
      end
      OP_SCANLINE: begin
        if (low_ctrl[7] && a.rendering_on) begin
          if (a.scanline == SPLIT_LINE) begin
            page_lo = 1'b1;
            page_hi = 1'b1;
          end
          if (alt_mode) begin
            if (a.scanline < SPLIT_LINE) begin
              page_lo = 1'b0;
              page_hi = 1'b0;
            end
          end else if (a.scanline == LAST_LINE) begin
            page_lo = 1'b0;
            page_hi = 1'b0;
          end
        end
      end
      default: restart_banks();
    endcase
    r.prg_bank      = prg;
    r.chr_low_page  = page_lo;
    r.chr_high_page = page_hi;
    return r;
  endfunction

  // Every hand-written result in the table is taken with the power-on banking:
  // start bank 15, low page 0 and high page 1.
  function automatic access_row_t mk_row(bsm_op_e op, logic [15:0] addr, logic [7:0] data,
                                         logic [8:0] line, logic render, logic typed,
                                         logic [7:0] rd, logic ram);
    access_row_t r;
    r.access.operation    = op;
    r.access.address      = addr;
    r.access.write_data   = data;
    r.access.scanline     = line;
    r.access.rendering_on = render;
    r.typed               = typed;
    r.want.read_data      = rd;
    r.want.ram_access     = ram;
    r.want.prg_bank       = RESET_START;
    r.want.chr_low_page   = 1'b0;
    r.want.chr_high_page  = 1'b1;
    return r;
  endfunction

  // Random traffic is mostly well-formed register accesses at their aliased
  // addresses and scanline events on the interesting lines, with some resets and
  // a tenth of pure noise. Fields that an operation ignores stay random.
  function automatic bsm_item_t random_access();
    bsm_item_t   a;
    int unsigned pick;
    int unsigned sub;
    logic [15:0] alias_bits;
    a.operation    = bsm_op_e'($urandom_range(0, 3));
    a.address      = 16'($urandom);
    a.write_data   = 8'($urandom);
    a.scanline     = 9'($urandom_range(0, 261));
    a.rendering_on = 1'($urandom);
    pick       = $urandom_range(0, 99);
    sub        = $urandom_range(0, 5);
    alias_bits = 16'($urandom) & 16'h0CFF;
    if (pick < 35) begin
      a.operation = OP_WRITE;
      case (sub)
        0: begin
          // Mostly with bit 7 set, so that scanline events have an effect.
          a.address = LOW_CTRL_SEL | alias_bits;
          if ($urandom_range(0, 3) != 0) a.write_data[7] = 1'b1;
        end
        1: a.address = HIGH_BITS_SEL | alias_bits;
        2: a.address = SECURITY_SEL | alias_bits;
        3: begin
          a.address = STROBE_ADDR;
          if ($urandom_range(0, 1) == 0) a.write_data = '0;
        end
        4: begin
          a.address = FORCE_ADDR;
          if ($urandom_range(0, 1) == 0) a.write_data = FORCE_BYTE;
        end
        default: a.address = 16'($urandom_range(RAM_BASE, 16'hFFFF));
      endcase
    end else if (pick < 55) begin
      a.operation = OP_READ;
      case (sub)
        0, 1:    a.address = SEC_READ_SEL | (alias_bits & 16'h08FF);
        2, 3:    a.address = GATED_READ_SEL | (alias_bits & 16'h08FF);
        4:       a.address = 16'($urandom_range(0, RAM_BASE - 1));
        default: a.address = 16'($urandom_range(RAM_BASE, 16'hFFFF));
      endcase
    end else if (pick < 85) begin
      a.operation = OP_SCANLINE;
      case (sub)
        0, 1:    a.scanline = SPLIT_LINE;
        2:       a.scanline = LAST_LINE;
        3:       a.scanline = 9'($urandom_range(0, SPLIT_LINE - 1));
        default: ;
      endcase
      a.rendering_on = ($urandom_range(0, 6) != 0);
    end else if (pick < 90) begin
      a.operation = OP_RESET;
    end
    return a;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Presents one access and returns at the clock edge of its transfer. The valid
  // is left high so that the next access can follow without a bubble.
  task automatic send_access(input bsm_item_t a, input logic typed, input bsm_result_t want);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, a.rendering_on, a.scanline, a.write_data, a.address};
    s_axis_tuser  <= a.operation;
    row_typed     <= typed;
    row_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input bsm_cfg_idx_e idx, input logic [PrgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_access(random_access(), 1'b0, '0);
  endtask

  // Lets every outstanding result come back, so that the pipeline is empty
  // before the configuration is touched.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Result-side flow control: ready stretches alternate with stall bursts.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Monitor: all transfers are sampled at the clock edge, so the values seen are
  // those that were present at the edge. Results are checked before the access of
  // the same edge is predicted; a result can never belong to that access.
  always @(posedge clk_i) begin
    bsm_item_t   seen;
    bsm_result_t got;
    bsm_result_t want;
    logic        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.read_data     = m_axis_tdata[7:0];
        got.ram_access    = m_axis_tdata[8];
        got.prg_bank      = m_axis_tdata[20:9];
        got.chr_low_page  = m_axis_tdata[21];
        got.chr_high_page = m_axis_tdata[22];
        n_results++;
        if (pending_q.size() == 0) begin
          note_fault($sformatf("result %0d arrived with no access outstanding", n_results));
        end else begin
          want = pending_q.pop_front();
          if (got.read_data !== want.read_data || got.ram_access !== want.ram_access ||
              got.prg_bank !== want.prg_bank || got.chr_low_page !== want.chr_low_page ||
              got.chr_high_page !== want.chr_high_page) begin
            note_fault($sformatf(
                {"result %0d: expected rd=%02h ram=%0b prg=%03h pages=%0b/%0b,",
                 " got rd=%02h ram=%0b prg=%03h pages=%0b/%0b"},
                n_results, want.read_data, want.ram_access, want.prg_bank,
                want.chr_low_page, want.chr_high_page, got.read_data, got.ram_access,
                got.prg_bank, got.chr_low_page, got.chr_high_page));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        if (cfg_index_i == CFG_ALT_CHR_MODE) alt_mode = cfg_data_i[0];
        else start_bank = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        seen.operation    = bsm_op_e'(s_axis_tuser);
        seen.address      = s_axis_tdata[15:0];
        seen.write_data   = s_axis_tdata[23:16];
        seen.scanline     = s_axis_tdata[32:24];
        seen.rendering_on = s_axis_tdata[33];
        want = map_access(seen);
        // The model still runs on a typed row so that its state stays in step.
        if (row_typed) want = row_want;
        pending_q.push_back(want);
        n_accesses++;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("testbench failed");
    $finish;
  end

  initial begin
    access_row_t corner_rows[25];
    int unsigned settings;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_ALT_CHR_MODE;
    cfg_data_i    = '0;
    row_typed     = 1'b0;
    row_want      = '0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    fault_count   = 0;
    n_accesses    = 0;
    n_results     = 0;
    stuck_cycles  = 0;
    settings      = 1;
    alt_mode      = 1'b0;
    start_bank    = RESET_START;
    restart_banks();
    page_lo       = 1'b0;
    page_hi       = 1'b1;
    rst_ni        = 1'b0;

    // Corner cases, run with the power-on configuration. The first rows leave the
    // banking untouched, so their results can be written down directly.
    corner_rows = '{
      // Open bus below the window, both address extremes, RAM read.
      mk_row(OP_READ,     16'h0000, 8'h00,   0, 1'b0, 1'b1, 8'h00, 1'b0),
      mk_row(OP_READ,     16'h4FFF, 8'hFF, 261, 1'b1, 1'b1, 8'h4F, 1'b0),
      mk_row(OP_READ,     16'hFFFF, 8'h00,   0, 1'b0, 1'b1, 8'h00, 1'b1),
      // Security read after reset, and a window read that matches nothing.
      mk_row(OP_READ,     16'h5100, 8'h00,   0, 1'b0, 1'b1, 8'h00, 1'b0),
      mk_row(OP_READ,     16'h5FFF, 8'h00,   0, 1'b0, 1'b1, 8'h04, 1'b0),
      // A RAM write and a write just below the window change nothing.
      mk_row(OP_WRITE,    16'h6000, 8'hFF,   0, 1'b0, 1'b1, 8'h00, 1'b1),
      mk_row(OP_WRITE,    16'h401F, 8'h00,   0, 1'b0, 1'b1, 8'h00, 1'b0),
      // Security byte, then the gated read before and after the trigger flips.
      mk_row(OP_WRITE,    16'h5300, 8'hA5,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_READ,     16'h5100, 8'h00,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_READ,     16'h5500, 8'h00,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_WRITE,    16'h5101, 8'h00,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_READ,     16'h5500, 8'h00,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      // A nonzero strobe byte rearms it; the next zero flips the trigger back.
      mk_row(OP_WRITE,    16'h5101, 8'h80,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_WRITE,    16'h5101, 8'h00,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      // All-ones high bank byte, then a low control byte with bit 7 set for the scanline logic.
      mk_row(OP_WRITE,    16'h5200, 8'hFF,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_WRITE,    16'h5000, 8'h83, 261, 1'b1, 1'b0, 8'h00, 1'b0),
      // Split line, last line with rendering off and on.
      mk_row(OP_SCANLINE, 16'h0000, 8'h00, 128, 1'b1, 1'b0, 8'h00, 1'b0),
      mk_row(OP_SCANLINE, 16'h0000, 8'h00, 239, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_SCANLINE, 16'h0000, 8'h00, 239, 1'b1, 1'b0, 8'h00, 1'b0),
      // Bit 7 cleared on an early line restores the 8K layout; scanlines then
      // have no effect.
      mk_row(OP_WRITE,    16'h5000, 8'h00, 127, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_SCANLINE, 16'h0000, 8'h00, 128, 1'b1, 1'b0, 8'h00, 1'b0),
      // Forced bank, the same address with other data, a window write that
      // matches no group.
      mk_row(OP_WRITE,    16'h5100, 8'h06,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_WRITE,    16'h5100, 8'h05,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      mk_row(OP_WRITE,    16'h4020, 8'h12,   0, 1'b0, 1'b0, 8'h00, 1'b0),
      // The reset operation keeps the pages left by the early-line write.
      mk_row(OP_RESET,    16'h0000, 8'h00,   0, 1'b0, 1'b1, 8'h00, 1'b0)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_rows[i]) begin
      send_access(corner_rows[i].access, corner_rows[i].typed, corner_rows[i].want);
    end
    drain();

    // Variant board with the lowest start bank.
    write_reg(CFG_ALT_CHR_MODE, 12'd1);
    write_reg(CFG_START_PRG_BANK, 12'd0);
    settings++;
    run_random(PHASE_ITEMS);
    drain();

    // Standard board with the highest start bank.
    write_reg(CFG_ALT_CHR_MODE, 12'd0);
    write_reg(CFG_START_PRG_BANK, 12'hFFF);
    settings++;
    run_random(PHASE_ITEMS);
    drain();

    write_reg(CFG_ALT_CHR_MODE, 12'd1);
    write_reg(CFG_START_PRG_BANK, 12'($urandom_range(1, 4094)));
    settings++;
    run_random(PHASE_ITEMS);
    drain();

    // Last phase at full rate on both sides.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(CFG_ALT_CHR_MODE, 12'd0);
    write_reg(CFG_START_PRG_BANK, 12'($urandom_range(1, 4094)));
    settings++;
    run_random(PHASE_ITEMS);
    drain();

    $display("Covered %0d accesses under %0d register settings: corner cases, then random",
             n_accesses, settings);
    $display("register traffic with gaps and stalls; %0d results checked, %0d faults.",
             n_results, fault_count);
    if (fault_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
